// ===== src/signed_shift_subtract_divider_macros.svh =====
// Assertion helpers shared by the divider RTL.
`ifndef SIGNED_SHIFT_SUBTRACT_DIVIDER_MACROS_SVH
`define SIGNED_SHIFT_SUBTRACT_DIVIDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ssd_pkg.sv =====
`timescale 1ns / 1ps

package ssd_pkg;

  // Operand and result width
  localparam int DATA_WIDTH = 32;

  // Step counter covers one step per quotient bit
  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

  // Largest positive value, used for saturation
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } ssd_state_t;

  // Control broadcast from the sequencer to the cell row and output stage
  typedef struct packed {
    logic load;    // transfer accepted: load operands into the cells
    logic step;    // one shift/subtract step
    logic finish;  // fix-up and write the result register
  } ssd_ctl_t;

endpackage

// ===== src/ssd_cell.sv =====
`timescale 1ns / 1ps

// One bit slice of the divider: remainder bit, dividend/quotient bit,
// divisor magnitude bit, and one stage of the borrow chain.
module ssd_cell
  import ssd_pkg::*;
(
  input  logic     clk,
  input  ssd_ctl_t ctl,
  input  logic     ld_dq,
  input  logic     ld_dvs,
  input  logic     rem_in,
  input  logic     dq_in,
  input  logic     bor_in,
  input  logic     fit,
  output logic     rem_out,
  output logic     dq_out,
  output logic     bor_out
);

  logic rem_r, rem_nxt;
  logic dq_r, dq_nxt;
  logic dvs_r, dvs_nxt;
  logic diff;

  // Subtract the divisor bit from the shifted remainder bit
  always_comb begin
    diff    = rem_in ^ dvs_r ^ bor_in;
    bor_out = (~rem_in & dvs_r) | (~(rem_in ^ dvs_r) & bor_in);
  end

  // Next slice state
  always_comb begin
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    dvs_nxt = dvs_r;
    if (ctl.load) begin
      rem_nxt = 1'b0;
      dq_nxt  = ld_dq;
      dvs_nxt = ld_dvs;
    end else if (ctl.step) begin
      rem_nxt = fit ? diff : rem_in;
      dq_nxt  = dq_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rem_out = rem_r;
  assign dq_out  = dq_r;

endmodule

// ===== src/ssd_ctrl.sv =====
`timescale 1ns / 1ps

// Sequencer: accepts a transfer, runs one step per quotient bit, then
// finishes once the result register is free.
module ssd_ctrl
  import ssd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_free,
  output ssd_ctl_t ctl
);

  ssd_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and control strobes
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ctl.step   = 1'b0;
    ctl.finish = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ctl.finish = 1'b1;
          in_stall   = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    ctl.load = in_valid && !in_stall;
    if (ctl.load) begin
      state_nxt = ST_RUN;
      cnt_nxt   = '0;
    end
  end

endmodule

// ===== src/signed_shift_subtract_divider.sv =====
`timescale 1ns / 1ps
// Signed 32-bit divider, quotient truncated toward zero.
// Input channel: in_dividend, in_divisor with in_valid / in_stall; a transfer
// takes place on a clock edge with in_valid high and in_stall low.
// Result channel: out_quotient, out_saturated, out_div_by_zero with
// out_valid / out_stall, transferred the same way.
// The input transfer is followed by one shift/subtract step per quotient bit
// through the row of bit-slice cells, where each step's subtract ripples a
// borrow across all slices, then by sign and saturation fix-up as the result
// is written to the output register. A new item is not taken until the last
// one finishes; the next transfer is taken in the same cycle that the previous
// result is written to the output register.
// A zero divisor returns quotient 0 with out_div_by_zero set; the most
// negative value over minus one returns the largest positive value with
// out_saturated set.
// Reset clears the sequencer and the output valid; no item is in flight.
// While the receiver stalls, the result is held; a following item still
// runs its steps and then waits, with in_stall high, until the result moves.
`include "signed_shift_subtract_divider_macros.svh"

module signed_shift_subtract_divider
  import ssd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_dividend,
  input  logic signed [DATA_WIDTH-1:0] in_divisor,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_quotient,
  output logic                         out_saturated,
  output logic                         out_div_by_zero
);

  ssd_ctl_t ctl;
  logic out_free;

  logic [DATA_WIDTH-1:0] dvd_u, dvs_u, dvd_mag, dvs_mag;
  logic dvd_neg, dvs_neg, same_in, dz_in;
  logic same_r, dz_r;

  logic [DATA_WIDTH-1:0] rem, dq, bor;
  logic fit;

  logic [DATA_WIDTH-1:0] q_fix;
  logic sat_fix;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_q_r;
  logic                  out_sat_r, out_dz_r;

  // Sequencer
  ssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // Operand magnitudes and sign classification
  always_comb begin
    dvd_u   = $unsigned(in_dividend);
    dvs_u   = $unsigned(in_divisor);
    dvd_neg = dvd_u[DATA_WIDTH-1];
    dvs_neg = dvs_u[DATA_WIDTH-1];
    dvd_mag = dvd_neg ? (DATA_WIDTH'(0) - dvd_u) : dvd_u;
    dvs_mag = dvs_neg ? (DATA_WIDTH'(0) - dvs_u) : dvs_u;
    dz_in   = (dvs_u == '0);
    same_in = ((dvd_u != '0) && !dvd_neg && !dvs_neg) || (dvd_neg && dvs_neg);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      same_r <= same_in;
      dz_r   <= dz_in;
    end
  end

  // Row of bit-slice cells; the top dividend bit feeds the remainder LSB
  // and the quotient bit enters at the bottom of the dividend chain
  assign fit = ~bor[DATA_WIDTH-1];

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      ssd_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .ld_dq   (dvd_mag[i]),
        .ld_dvs  (dvs_mag[i]),
        .rem_in  (dq[DATA_WIDTH-1]),
        .dq_in   (fit),
        .bor_in  (1'b0),
        .fit     (fit),
        .rem_out (rem[i]),
        .dq_out  (dq[i]),
        .bor_out (bor[i])
      );
    end else begin : g_rest
      ssd_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .ld_dq   (dvd_mag[i]),
        .ld_dvs  (dvs_mag[i]),
        .rem_in  (rem[i-1]),
        .dq_in   (dq[i-1]),
        .bor_in  (bor[i-1]),
        .fit     (fit),
        .rem_out (rem[i]),
        .dq_out  (dq[i]),
        .bor_out (bor[i])
      );
    end
  end

  // Sign and saturation fix-up of the quotient magnitude
  always_comb begin
    sat_fix = 1'b0;
    if (dz_r) begin
      q_fix = '0;
    end else if (same_r) begin
      sat_fix = dq[DATA_WIDTH-1];
      q_fix   = dq[DATA_WIDTH-1] ? MAX_POS : dq;
    end else begin
      q_fix = DATA_WIDTH'(0) - dq;
    end
  end

  // Output register
  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid_nxt = ctl.finish || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_q_r   <= q_fix;
      out_sat_r <= sat_fix;
      out_dz_r  <= dz_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_quotient    = $signed(out_q_r);
  assign out_saturated   = out_sat_r;
  assign out_div_by_zero = out_dz_r;

  // Checks
  `SSD_ASSERT_IMP(a_dz_zero, clk, rst_n, out_valid && out_div_by_zero, (out_q_r == '0) && !out_sat_r, "divide by zero result not clean")
  `SSD_ASSERT_IMP(a_sat_max, clk, rst_n, out_valid && out_saturated, out_q_r == MAX_POS, "saturated result not max positive")
  `SSD_ASSERT_NXT(a_busy_after_load, clk, rst_n, ctl.load, in_stall && !ctl.finish, "input not stalled while dividing")
  `SSD_ASSERT_IMP(a_finish_free, clk, rst_n, ctl.finish, out_free && !ctl.step, "result written into a busy output")

endmodule

// ===== bench/tb_signed_shift_subtract_divider.sv =====
`timescale 1ns / 1ps

module tb_signed_shift_subtract_divider
  import ssd_pkg::*;
();

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_OPS = 1000;
  localparam logic signed [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] dividend;
    logic signed [DATA_WIDTH-1:0] divisor;
  } div_op_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quotient;
    logic                         saturated;
    logic                         div_by_zero;
  } div_result_t;

  typedef enum logic [1:0] {
    OPND_FULL,
    OPND_SMALL,
    OPND_EDGE,
    OPND_POW2
  } operand_shape_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [DATA_WIDTH-1:0] in_dividend = '0;
  logic signed [DATA_WIDTH-1:0] in_divisor = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [DATA_WIDTH-1:0] out_quotient;
  logic                         out_saturated;
  logic                         out_div_by_zero;

  div_op_t     pending_ops[$];
  div_result_t quotients_due[$];

  int ops_total = 0;
  int ops_sent = 0;
  int results_seen = 0;
  int mismatch_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int mode_left = 0;
  int stall_period = 2;
  stall_mode_t stall_mode = STALL_NONE;

  signed_shift_subtract_divider u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_dividend     (in_dividend),
    .in_divisor      (in_divisor),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_quotient    (out_quotient),
    .out_saturated   (out_saturated),
    .out_div_by_zero (out_div_by_zero)
  );

  always #6 clk = ~clk;

  // Truncating signed division, magnitude built MSB first by shift/subtract
  function automatic div_result_t predict_division(logic signed [DATA_WIDTH-1:0] num,
                                                   logic signed [DATA_WIDTH-1:0] den);
    div_result_t           res;
    logic [DATA_WIDTH-1:0] num_mag;
    logic [DATA_WIDTH-1:0] den_mag;
    logic [DATA_WIDTH-1:0] q_mag;
    logic [DATA_WIDTH:0]   partial;
    logic                  same_sign;
    res = '0;
    if (den == '0) begin
      res.div_by_zero = 1'b1;
    end else begin
      num_mag = num[DATA_WIDTH-1] ? -num : num;
      den_mag = den[DATA_WIDTH-1] ? -den : den;
      partial = '0;
      q_mag = '0;
      for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
        partial = {partial[DATA_WIDTH-1:0], num_mag[i]};
        q_mag = q_mag << 1;
        if (partial >= {1'b0, den_mag}) begin
          partial = partial - {1'b0, den_mag};
          q_mag[0] = 1'b1;
        end
      end
      // zero dividend counts as not positive, so it takes the negate path
      same_sign = (num != '0 && !num[DATA_WIDTH-1] && !den[DATA_WIDTH-1]) ||
                  (num[DATA_WIDTH-1] && den[DATA_WIDTH-1]);
      if (same_sign) begin
        if (q_mag > MAX_POS) begin
          res.quotient = MAX_POS;
          res.saturated = 1'b1;
        end else begin
          res.quotient = q_mag;
        end
      end else begin
        res.quotient = '0 - q_mag;
      end
    end
    return res;
  endfunction

  // Operand mix: full range, small values, extremes, powers of two
  function automatic logic signed [DATA_WIDTH-1:0] random_operand();
    operand_shape_t               shape;
    logic signed [DATA_WIDTH-1:0] v;
    shape = operand_shape_t'($urandom_range(0, 3));
    case (shape)
      OPND_FULL: v = $urandom;
      OPND_SMALL: v = $urandom_range(0, 300);
      OPND_EDGE: begin
        case ($urandom_range(0, 3))
          0: v = MIN_NEG;
          1: v = MAX_POS;
          2: v = '0;
          default: v = 1;
        endcase
      end
      default: v = (DATA_WIDTH'(1) << $urandom_range(0, DATA_WIDTH - 1)) - $urandom_range(0, 1);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic add_op(logic signed [DATA_WIDTH-1:0] num, logic signed [DATA_WIDTH-1:0] den);
    div_op_t op;
    op.dividend = num;
    op.divisor = den;
    pending_ops = {pending_ops, op};
  endtask

  // Stimulus, reset and end of run
  initial begin
    // zero divisor
    add_op(0, 0);
    add_op(MIN_NEG, 0);
    add_op(MAX_POS, 0);
    add_op(-1, 0);
    // most negative over minus one saturates
    add_op(MIN_NEG, -1);
    // zero dividend
    add_op(0, 1);
    add_op(0, -1);
    add_op(0, MIN_NEG);
    // extremes
    add_op(MIN_NEG, 1);
    add_op(MIN_NEG, MIN_NEG);
    add_op(MIN_NEG, MAX_POS);
    add_op(MIN_NEG, 2);
    add_op(MAX_POS, MAX_POS);
    add_op(MAX_POS, MIN_NEG);
    add_op(MAX_POS, 1);
    add_op(MAX_POS, -1);
    add_op(1, MIN_NEG);
    add_op(-1, MAX_POS);
    add_op(-1, -1);
    add_op(1, -1);
    // sign combinations with a remainder
    add_op(7, 2);
    add_op(-7, 2);
    add_op(7, -2);
    add_op(-7, -2);
    add_op(5, 7);
    for (int n = 0; n < RANDOM_OPS; n++) begin
      add_op(random_operand(), random_operand());
    end
    ops_total = pending_ops.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (!(ops_sent == ops_total && quotients_due.size() == 0)) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Driver: bursts of transfers with random gaps; payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        quotients_due = {quotients_due, predict_division(in_dividend, in_divisor)};
        ops_sent <= ops_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_ops.size() > 0) begin
          in_valid <= 1'b1;
          in_dividend <= pending_ops[0].dividend;
          in_divisor <= pending_ops[0].divisor;
          pending_ops.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            case ($urandom_range(0, 3))
              0: gap_left <= 0;
              1: gap_left <= $urandom_range(1, 3);
              default: gap_left <= $urandom_range(1, 40);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      mode_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= 40) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        stall_period <= $urandom_range(2, 40);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 80);
        default: out_stall <= (mode_left % stall_period) < (stall_period / 2);
      endcase
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (quotients_due.size() == 0) begin
        $display("%0t: unexpected result q=%0d sat=%0b dz=%0b", $time,
                 out_quotient, out_saturated, out_div_by_zero);
        mismatch_cnt++;
      end else begin
        if ({out_quotient, out_saturated, out_div_by_zero} !== quotients_due[0]) begin
          $display("%0t: expected q=%0d sat=%0b dz=%0b, got q=%0d sat=%0b dz=%0b", $time,
                   quotients_due[0].quotient, quotients_due[0].saturated,
                   quotients_due[0].div_by_zero,
                   out_quotient, out_saturated, out_div_by_zero);
          mismatch_cnt++;
        end
        quotients_due.pop_front();
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
